/* rtl/core/binary_diff_patch_encoder_core_assert.svh */
// Assertion helpers shared by bdpe_dpath and bdpe_pack
`ifndef BINARY_DIFF_PATCH_ENCODER_CORE_ASSERT_SVH
`define BINARY_DIFF_PATCH_ENCODER_CORE_ASSERT_SVH

// expression holds on every edge out of reset
`define BDPE_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("bdpe assertion failed");

// consequent holds on the same edge as the antecedent
`define BDPE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bdpe assertion failed");

`endif

/* rtl/core/bdpe_pkg.sv */
package bdpe_pkg;

	localparam int HDR_BYTES  = 9;
	localparam int BEAT_BYTES = 16;

	typedef struct packed {
		logic [7:0] orig_byte;
		logic [7:0] mod_byte;
		logic       end_of_file;
	} in_word_t;

	typedef struct packed {
		logic [63:0] beat_low;
		logic [63:0] beat_high;
		logic [4:0]  beat_bytes;
		logic        record_last;
	} out_word_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic issue;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic close;
		logic issue_last;
	} sts_t;

	// one record byte on its way to the beat packer
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
	} byte_word_t;

endpackage

/* rtl/core/bdpe_ctrl.sv */
module bdpe_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          pack_ready,
	input  bdpe_pkg::sts_t sts,
	output bdpe_pkg::cmd_t cmd
);
	import bdpe_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EMIT = 1'b1;

	logic state_q;

	assign in_ready   = (state_q == S_IDLE);
	assign cmd.accept = in_valid && (state_q == S_IDLE);
	assign cmd.issue  = (state_q == S_EMIT) && pack_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.accept && sts.close) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (cmd.issue && sts.issue_last) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/bdpe_dpath.sv */
`include "binary_diff_patch_encoder_core_assert.svh"

module bdpe_dpath #(
	parameter int MAX_RUN     = 255,
	parameter int CHUNK_BYTES = 1048576
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_wr_data,
	input  bdpe_pkg::in_word_t   in_data,
	input  bdpe_pkg::cmd_t       cmd,
	input  logic                 adv,
	output bdpe_pkg::sts_t       sts,
	output bdpe_pkg::byte_word_t rec_byte
);
	import bdpe_pkg::*;

	localparam int AW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
	localparam int LW = $clog2(MAX_RUN + 1);
	localparam int KW = $clog2(HDR_BYTES + 2 * MAX_RUN + 1);
	localparam int CW = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;

	localparam logic [1:0] SEL_HDR = 2'd0;
	localparam logic [1:0] SEL_NEW = 2'd1;
	localparam logic [1:0] SEL_OLD = 2'd2;

	logic          undo_q;
	logic [63:0]   pos_q;
	logic [CW-1:0] chunk_q;
	logic [63:0]   run_start_q;
	logic [LW-1:0] run_len_q;
	logic [KW-1:0] k_q;

	logic [7:0] new_mem [MAX_RUN];
	logic [7:0] old_mem [MAX_RUN];

	logic       valid_s1;
	logic [1:0] sel_s1;
	logic [7:0] hdr_s1;
	logic       last_s1;
	logic [7:0] new_rd_s1;
	logic [7:0] old_rd_s1;

	logic          differ;
	logic          chunk_last;
	logic [LW-1:0] len_nx;
	logic          wr_en;
	logic [KW-1:0] len_k;
	logic [KW-1:0] rec_len;
	logic [KW-1:0] off;
	logic          is_hdr;
	logic          is_new;
	logic [AW-1:0] rd_addr;
	logic [7:0]    hdr_byte;
	logic [1:0]    sel;

	// closing decision for the word on the input
	assign differ     = in_data.orig_byte != in_data.mod_byte;
	assign chunk_last = (chunk_q == CW'(CHUNK_BYTES - 1)) || (&pos_q);
	assign len_nx     = run_len_q + LW'(differ);
	assign wr_en      = cmd.accept && differ;
	assign sts.close  = (len_nx != '0) && (!differ || (len_nx == LW'(MAX_RUN)) ||
		chunk_last || in_data.end_of_file);

	// record byte sequencing
	assign len_k   = KW'(run_len_q);
	assign rec_len = KW'(HDR_BYTES) + len_k + (undo_q ? len_k : '0);
	assign sts.issue_last = (k_q == rec_len - KW'(1));
	assign off     = k_q - KW'(HDR_BYTES);
	assign is_hdr  = k_q < KW'(HDR_BYTES);
	assign is_new  = off < len_k;
	assign rd_addr = is_hdr ? '0 : (is_new ? AW'(off) : AW'(off - len_k));
	assign sel     = is_hdr ? SEL_HDR : (is_new ? SEL_NEW : SEL_OLD);

	always_comb begin
		if (k_q == KW'(HDR_BYTES - 1)) begin
			hdr_byte = 8'(run_len_q);
		end else begin
			hdr_byte = run_start_q[{k_q[2:0], 3'b000} +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			undo_q      <= 1'b0;
			pos_q       <= '0;
			chunk_q     <= '0;
			run_start_q <= '0;
			run_len_q   <= '0;
			k_q         <= '0;
			valid_s1    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				undo_q <= cfg_wr_data;
			end
			if (cmd.accept) begin
				if (in_data.end_of_file) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + 64'd1;
				end
				if (in_data.end_of_file || chunk_last) begin
					chunk_q <= '0;
				end else begin
					chunk_q <= chunk_q + CW'(1);
				end
				if (differ && (run_len_q == '0)) begin
					run_start_q <= pos_q;
				end
				run_len_q <= len_nx;
				k_q       <= '0;
			end else if (cmd.issue) begin
				k_q <= k_q + KW'(1);
				if (sts.issue_last) begin
					run_len_q <= '0;
				end
			end
			if (adv) begin
				valid_s1 <= cmd.issue;
			end
		end
	end

	// run storage: one write per accepted differing word, registered read while sending
	always_ff @(posedge clk) begin
		if (wr_en) begin
			new_mem[AW'(run_len_q)] <= in_data.mod_byte;
			old_mem[AW'(run_len_q)] <= in_data.orig_byte;
		end
		if (adv) begin
			new_rd_s1 <= new_mem[rd_addr];
			old_rd_s1 <= old_mem[rd_addr];
			sel_s1    <= sel;
			hdr_s1    <= hdr_byte;
			last_s1   <= sts.issue_last;
		end
	end

	always_comb begin
		rec_byte.valid = valid_s1;
		rec_byte.last  = last_s1;
		case (sel_s1)
			SEL_HDR: rec_byte.data = hdr_s1;
			SEL_NEW: rec_byte.data = new_rd_s1;
			SEL_OLD: rec_byte.data = old_rd_s1;
			default: rec_byte.data = hdr_s1;
		endcase
	end

	`BDPE_ASSERT_ALWAYS(a_run_len_bound, clk, arst_n, run_len_q <= LW'(MAX_RUN))
	`BDPE_ASSERT_IMPLIES(a_issue_in_record, clk, arst_n, cmd.issue, k_q < rec_len)

endmodule

/* rtl/core/bdpe_pack.sv */
`include "binary_diff_patch_encoder_core_assert.svh"

module bdpe_pack (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bdpe_pkg::byte_word_t rec_byte,
	output logic                 adv,
	output logic                 out_valid,
	input  logic                 out_ready,
	output bdpe_pkg::out_word_t  out_data
);
	import bdpe_pkg::*;

	logic [127:0] buf_q;
	logic [4:0]   cnt_q;
	logic         done_q;
	logic         last_q;
	logic         out_valid_q;
	out_word_t    out_q;

	logic         out_free;
	logic         xfer;
	logic         fresh;
	logic [3:0]   lane;
	logic [127:0] buf_nx;
	logic [4:0]   cnt_nx;

	assign out_free = !out_valid_q || out_ready;
	assign adv      = !done_q || out_free;
	assign xfer     = done_q && out_free;

	// start a new beat with clean lanes once the previous one is complete
	assign fresh  = done_q || (cnt_q == '0);
	assign lane   = fresh ? 4'd0 : cnt_q[3:0];
	assign cnt_nx = (fresh ? 5'd0 : cnt_q) + 5'd1;

	always_comb begin
		buf_nx = fresh ? '0 : buf_q;
		buf_nx[{lane, 3'b000} +: 8] = rec_byte.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				if (rec_byte.valid) begin
					cnt_q  <= cnt_nx;
					done_q <= (cnt_nx == 5'(BEAT_BYTES)) || rec_byte.last;
				end else if (done_q) begin
					cnt_q  <= '0;
					done_q <= 1'b0;
				end
			end
			if (xfer) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && rec_byte.valid) begin
			buf_q  <= buf_nx;
			last_q <= rec_byte.last;
		end
		if (xfer) begin
			out_q.beat_low    <= buf_q[63:0];
			out_q.beat_high   <= buf_q[127:64];
			out_q.beat_bytes  <= cnt_q;
			out_q.record_last <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`BDPE_ASSERT_IMPLIES(a_beat_not_empty, clk, arst_n, out_valid_q, out_q.beat_bytes != 5'd0)
	`BDPE_ASSERT_IMPLIES(a_beat_full_unless_last, clk, arst_n, done_q && !last_q,
		cnt_q == 5'(BEAT_BYTES))

endmodule

/* rtl/core/binary_diff_patch_encoder_core.sv */
// Difference record encoder.
// Input channel (in_valid/in_ready, in_data): one word per file position, the
// original byte, the modified byte and an end-of-file flag. A run of differing
// bytes is closed by an equal byte, by MAX_RUN bytes, by the last byte of a
// CHUNK_BYTES chunk (or the 2^64 wrap) or by end of file, and becomes one record.
// Output channel (out_valid/out_ready, out_data): the record as 16-byte words:
// 8-byte little-endian start offset, length byte, modified bytes and, with
// undo_enable set, original bytes; record_last flags the final word.
// cfg_wr_en/cfg_wr_data write undo_enable; write it only while idle.
// Flow: a word that closes no run leaves in_ready high. A word that closes
// a run holds in_ready low while its 9 + L (or 9 + 2L with undo) record bytes
// are sent, one per cycle unless the packer stalls; data bytes come from the
// run memory. An output word is registered when full or at the record's end.
// A stalled receiver holds the output register; the packer then stops and
// in_ready stays low until the record has been fully read out.
// Reset clears position, run state and undo_enable; no clearing pass.
module binary_diff_patch_encoder_core #(
	parameter int MAX_RUN     = 255,
	parameter int CHUNK_BYTES = 1048576
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  bdpe_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output bdpe_pkg::out_word_t out_data
);
	import bdpe_pkg::*;

	cmd_t       cmd;
	sts_t       sts;
	byte_word_t rec_byte;
	logic       adv;

	bdpe_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pack_ready (adv),
		.sts        (sts),
		.cmd        (cmd)
	);

	bdpe_dpath #(
		.MAX_RUN     (MAX_RUN),
		.CHUNK_BYTES (CHUNK_BYTES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (in_data),
		.cmd         (cmd),
		.adv         (adv),
		.sts         (sts),
		.rec_byte    (rec_byte)
	);

	bdpe_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_byte  (rec_byte),
		.adv       (adv),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
